@@ hw/rtl/dnsx_pkg.sv @@
// package: item types, parse phases and protocol constants for the dns reply extractor
package dnsx_pkg;

  // one input item: a payload byte and the end-of-packet mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // one result item
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } out_t;

  // parse phases
  typedef enum logic [3:0] {
    PH_HEADER     = 4'd0,
    PH_QNAME      = 4'd1,
    PH_QTAIL      = 4'd2,
    PH_NAME_FIRST = 4'd3,
    PH_NAME_PTR   = 4'd4,
    PH_NAME_RUN   = 4'd5,
    PH_FIXED      = 4'd6,
    PH_DATA       = 4'd7,
    PH_IGNORE     = 4'd8
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_A    = 2'd1;
  localparam logic [1:0] KIND_AAAA = 2'd2;

  // header byte positions that close a field
  localparam logic [3:0] POS_ID    = 4'd1;
  localparam logic [3:0] POS_FLAGS = 4'd3;
  localparam logic [3:0] POS_QDCNT = 4'd5;
  localparam logic [3:0] POS_ANCNT = 4'd7;
  localparam logic [3:0] POS_HDEND = 4'd11;

  // record fixed-part byte positions
  localparam logic [3:0] POS_TYPE  = 4'd1;
  localparam logic [3:0] POS_RDLEN = 4'd9;

  // field values
  localparam logic [15:0] FLAG_RESPONSE = 16'h8000;
  localparam logic [15:0] RCODE_MASK    = 16'h000F;
  localparam logic [7:0]  PTR_MASK      = 8'hC0;
  localparam logic [15:0] TYPE_A        = 16'd1;
  localparam logic [15:0] TYPE_AAAA     = 16'd28;
  localparam logic [15:0] SIZE_A        = 16'd4;
  localparam logic [15:0] SIZE_AAAA     = 16'd16;
  localparam logic [15:0] QTAIL_LEN     = 16'd4;

endpackage

@@ hw/rtl/dnsx_parser.sv @@
// byte-wide dns reply parser: walks header, questions and answers, one byte per step
module dnsx_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  dnsx_pkg::in_t  item,
  input  logic [15:0]    expected_id,
  output dnsx_pkg::out_t res
);

  dnsx_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]   pos_r, pos_nxt;
  logic         good_r, good_nxt;
  logic [15:0]  fs_r, fs_nxt;
  logic [15:0]  q_r, q_nxt;
  logic [15:0]  ans_r, ans_nxt;
  logic [15:0]  bl_r, bl_nxt;
  logic         kind_a_r, kind_a_nxt;
  logic         kind_aaaa_r, kind_aaaa_nxt;
  logic         rec_a_r, rec_a_nxt;
  logic         rec_aaaa_r, rec_aaaa_nxt;
  logic         v4seen_r, v4seen_nxt;
  logic         v6seen_r, v6seen_nxt;
  logic [31:0]  v4_r, v4_nxt;
  logic [127:0] v6_r, v6_nxt;

  // next state for one byte, result taken before the end-of-packet clear
  always_comb begin
    logic       done;
    logic       done_a;
    logic       done_aaaa;
    logic [7:0] b;
    done          = 1'b0;
    done_a        = 1'b0;
    done_aaaa     = 1'b0;
    b             = item.data_byte;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    good_nxt      = good_r;
    fs_nxt        = fs_r;
    q_nxt         = q_r;
    ans_nxt       = ans_r;
    bl_nxt        = bl_r;
    kind_a_nxt    = kind_a_r;
    kind_aaaa_nxt = kind_aaaa_r;
    rec_a_nxt     = rec_a_r;
    rec_aaaa_nxt  = rec_aaaa_r;
    v4seen_nxt    = v4seen_r;
    v6seen_nxt    = v6seen_r;
    v4_nxt        = v4_r;
    v6_nxt        = v6_r;
    res.result_kind  = dnsx_pkg::KIND_NONE;
    res.address_high = 64'd0;
    res.address_low  = 64'd0;

    if (step) begin
      case (phase_r)
        dnsx_pkg::PH_HEADER: begin
          fs_nxt = {fs_r[7:0], b};
          if (pos_r == dnsx_pkg::POS_ID && fs_nxt != expected_id) good_nxt = 1'b0;
          if (pos_r == dnsx_pkg::POS_FLAGS &&
              ((fs_nxt & dnsx_pkg::FLAG_RESPONSE) == 16'd0 ||
               (fs_nxt & dnsx_pkg::RCODE_MASK) != 16'd0)) good_nxt = 1'b0;
          if (pos_r == dnsx_pkg::POS_QDCNT) q_nxt = fs_nxt;
          if (pos_r == dnsx_pkg::POS_ANCNT) begin
            ans_nxt = fs_nxt;
            if (fs_nxt == 16'd0) good_nxt = 1'b0;
          end
          if (pos_r == dnsx_pkg::POS_HDEND) begin
            if (!good_nxt) phase_nxt = dnsx_pkg::PH_IGNORE;
            else if (q_r == 16'd0) phase_nxt = dnsx_pkg::PH_NAME_FIRST;
            else phase_nxt = dnsx_pkg::PH_QNAME;
          end
          pos_nxt = pos_r + 4'd1;
        end
        dnsx_pkg::PH_QNAME: begin
          if (b == 8'd0) begin
            bl_nxt    = dnsx_pkg::QTAIL_LEN;
            phase_nxt = dnsx_pkg::PH_QTAIL;
          end
        end
        dnsx_pkg::PH_QTAIL: begin
          bl_nxt = bl_r - 16'd1;
          if (bl_nxt == 16'd0) begin
            q_nxt     = q_r - 16'd1;
            phase_nxt = (q_nxt == 16'd0) ? dnsx_pkg::PH_NAME_FIRST : dnsx_pkg::PH_QNAME;
          end
        end
        dnsx_pkg::PH_NAME_FIRST: begin
          pos_nxt = 4'd0;
          if ((b & dnsx_pkg::PTR_MASK) == dnsx_pkg::PTR_MASK) phase_nxt = dnsx_pkg::PH_NAME_PTR;
          else if (b == 8'd0) phase_nxt = dnsx_pkg::PH_FIXED;
          else phase_nxt = dnsx_pkg::PH_NAME_RUN;
        end
        dnsx_pkg::PH_NAME_PTR: begin
          phase_nxt = dnsx_pkg::PH_FIXED;
        end
        dnsx_pkg::PH_NAME_RUN: begin
          if (b == 8'd0) phase_nxt = dnsx_pkg::PH_FIXED;
        end
        dnsx_pkg::PH_FIXED: begin
          fs_nxt = {fs_r[7:0], b};
          if (pos_r == dnsx_pkg::POS_TYPE) begin
            kind_a_nxt    = (fs_nxt == dnsx_pkg::TYPE_A);
            kind_aaaa_nxt = (fs_nxt == dnsx_pkg::TYPE_AAAA);
          end
          if (pos_r == dnsx_pkg::POS_RDLEN) begin
            bl_nxt       = fs_nxt;
            rec_a_nxt    = kind_a_r && fs_nxt == dnsx_pkg::SIZE_A;
            rec_aaaa_nxt = kind_aaaa_r && fs_nxt == dnsx_pkg::SIZE_AAAA;
            // an empty record closes at once and is never an address
            if (fs_nxt == 16'd0) done = 1'b1;
            else phase_nxt = dnsx_pkg::PH_DATA;
          end
          pos_nxt = pos_r + 4'd1;
        end
        dnsx_pkg::PH_DATA: begin
          if (rec_a_r) v4_nxt = {v4_r[23:0], b};
          if (rec_aaaa_r && !v6seen_r) v6_nxt = {v6_r[119:0], b};
          bl_nxt = bl_r - 16'd1;
          if (bl_nxt == 16'd0) begin
            done      = 1'b1;
            done_a    = rec_a_r;
            done_aaaa = rec_aaaa_r;
          end
        end
        default: begin
        end
      endcase

      // record complete
      if (done) begin
        if (done_a) begin
          v4seen_nxt = 1'b1;
          phase_nxt  = dnsx_pkg::PH_IGNORE;
        end else begin
          if (done_aaaa) v6seen_nxt = 1'b1;
          ans_nxt   = ans_r - 16'd1;
          phase_nxt = (ans_nxt == 16'd0) ? dnsx_pkg::PH_IGNORE : dnsx_pkg::PH_NAME_FIRST;
        end
      end

      // result of the packet, then clear for the next one
      if (item.last_byte) begin
        if (v4seen_nxt) begin
          res.result_kind = dnsx_pkg::KIND_A;
          res.address_low = {32'd0, v4_nxt};
        end else if (v6seen_nxt) begin
          res.result_kind  = dnsx_pkg::KIND_AAAA;
          res.address_high = v6_nxt[127:64];
          res.address_low  = v6_nxt[63:0];
        end
        phase_nxt     = dnsx_pkg::PH_HEADER;
        pos_nxt       = 4'd0;
        good_nxt      = 1'b1;
        fs_nxt        = 16'd0;
        q_nxt         = 16'd0;
        ans_nxt       = 16'd0;
        bl_nxt        = 16'd0;
        kind_a_nxt    = 1'b0;
        kind_aaaa_nxt = 1'b0;
        rec_a_nxt     = 1'b0;
        rec_aaaa_nxt  = 1'b0;
        v4seen_nxt    = 1'b0;
        v6seen_nxt    = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dnsx_pkg::PH_HEADER;
      pos_r       <= 4'd0;
      good_r      <= 1'b1;
      fs_r        <= 16'd0;
      q_r         <= 16'd0;
      ans_r       <= 16'd0;
      bl_r        <= 16'd0;
      kind_a_r    <= 1'b0;
      kind_aaaa_r <= 1'b0;
      rec_a_r     <= 1'b0;
      rec_aaaa_r  <= 1'b0;
      v4seen_r    <= 1'b0;
      v6seen_r    <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      good_r      <= good_nxt;
      fs_r        <= fs_nxt;
      q_r         <= q_nxt;
      ans_r       <= ans_nxt;
      bl_r        <= bl_nxt;
      kind_a_r    <= kind_a_nxt;
      kind_aaaa_r <= kind_aaaa_nxt;
      rec_a_r     <= rec_a_nxt;
      rec_aaaa_r  <= rec_aaaa_nxt;
      v4seen_r    <= v4seen_nxt;
      v6seen_r    <= v6seen_nxt;
    end
  end

  // address shifters, fully refilled before they are reported
  always_ff @(posedge clk) begin
    v4_r <= v4_nxt;
    v6_r <= v6_nxt;
  end

endmodule

@@ hw/rtl/dns_response_address_extractor.sv @@
// top level: dns reply address extractor with config register and result register
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------------
//  input   | in_valid, in_ready, in_data    | one packet byte with end mark per item
//  result  | out_valid, out_ready, out_data | one kind and address per packet
//  config  | cfg_wr_en, cfg_wr_data         | expected transaction id, no wait
//
// One byte item is taken per clock while in_ready is high; the parser state
// updates in the same cycle. The result item is registered when the last byte
// of a packet is taken. A waiting result blocks only the last byte of the next
// packet; other bytes keep flowing into the parser.
// Synchronous active-low reset returns the parser to the header phase and the id to 0.
module dns_response_address_extractor (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dnsx_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dnsx_pkg::out_t out_data,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data
);

  logic [15:0]    expected_id_r;
  logic           in_fire;
  logic           out_valid_r, out_valid_nxt;
  dnsx_pkg::out_t out_data_r;
  dnsx_pkg::out_t res;

  // a packet end needs a free result slot
  assign in_ready = !out_valid_r || out_ready || !in_data.last_byte;
  assign in_fire  = in_valid && in_ready;

  // id register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= 16'd0;
    end else if (cfg_wr_en) begin
      expected_id_r <= cfg_wr_data;
    end
  end

  dnsx_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .item        (in_data),
    .expected_id (expected_id_r),
    .res         (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && in_data.last_byte) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_byte) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_kind == dnsx_pkg::KIND_NONE |->
      out_data_r.address_high == 64'd0 && out_data_r.address_low == 64'd0)
    else $error("empty result carries an address");

  a_v4_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_kind == dnsx_pkg::KIND_A |->
      out_data_r.address_high == 64'd0 && out_data_r.address_low[63:32] == 32'd0)
    else $error("ipv4 result has upper bits set");

  a_rise_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && in_data.last_byte))
    else $error("result without a packet end");

  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_byte |=> out_valid_r)
    else $error("packet end gave no result");

endmodule

@@ test/dns_response_address_extractor_tb.sv @@
// testbench: dns reply address extractor fed directed and random replies, checked by a parse model
`timescale 1ns / 100ps

module dns_response_address_extractor_tb;

  localparam int CLK_HALF       = 2;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int IDLE_PCT       = 7;
  localparam int DRAIN_GAP      = 4;
  // random traffic stops here, leaving room for the last two tests
  localparam int RANDOM_STOP    = 1110;
  localparam int REPLIES_PER_ID = 4;
  localparam int B2B_REPLIES    = 6;
  localparam int HOLD_REPLIES   = 6;
  localparam logic [15:0] CLASS_IN   = 16'd1;
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] FLAGS_OK   = 16'h8180;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  dnsx_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  dnsx_pkg::out_t out_data;
  logic           cfg_wr_en;
  logic [15:0]    cfg_wr_data;

  dns_response_address_extractor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // parse model state
  logic [15:0]      model_id;
  logic [15:0]      field_pos;
  dnsx_pkg::phase_t parse_phase;
  logic             hdr_ok;
  logic [15:0]      shift16;
  logic [15:0]      q_left;
  logic [15:0]      a_left;
  logic [15:0]      b_left;
  logic [15:0]      rec_type;
  logic [15:0]      rec_len;
  logic             v4_seen;
  logic             v6_seen;
  logic [31:0]      v4_addr;
  logic [127:0]     v6_addr;

  // expected addresses, one per packet, and the reply under construction
  dnsx_pkg::out_t address_q[$];
  logic [7:0]     pkt[$];

  int   mismatches;
  int   items_sent;
  int   cycle_count = 0;
  int   hold_request;
  logic calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- parse model

  function automatic void clear_parse();
    field_pos   = '0;
    parse_phase = dnsx_pkg::PH_HEADER;
    hdr_ok      = 1'b1;
    shift16     = '0;
    q_left      = '0;
    a_left      = '0;
    b_left      = '0;
    rec_type    = '0;
    rec_len     = '0;
    v4_seen     = 1'b0;
    v6_seen     = 1'b0;
    v4_addr     = '0;
    v6_addr     = '0;
  endfunction

  // a four-byte a record ends the walk; anything else uses up one answer
  function automatic void close_record();
    if (rec_type == dnsx_pkg::TYPE_A && rec_len == dnsx_pkg::SIZE_A) begin
      v4_seen     = 1'b1;
      parse_phase = dnsx_pkg::PH_IGNORE;
    end else begin
      if (rec_type == dnsx_pkg::TYPE_AAAA && rec_len == dnsx_pkg::SIZE_AAAA)
        v6_seen = 1'b1;
      a_left      = a_left - 16'd1;
      parse_phase = (a_left == 16'd0) ? dnsx_pkg::PH_IGNORE : dnsx_pkg::PH_NAME_FIRST;
    end
  endfunction

  function automatic void parse_reply_byte(input logic [7:0] b);
    case (parse_phase)
      dnsx_pkg::PH_HEADER: begin
        shift16 = {shift16[7:0], b};
        if (field_pos == dnsx_pkg::POS_ID && shift16 != model_id)
          hdr_ok = 1'b0;
        if (field_pos == dnsx_pkg::POS_FLAGS &&
            ((shift16 & dnsx_pkg::FLAG_RESPONSE) == '0 ||
             (shift16 & dnsx_pkg::RCODE_MASK) != '0))
          hdr_ok = 1'b0;
        if (field_pos == dnsx_pkg::POS_QDCNT)
          q_left = shift16;
        if (field_pos == dnsx_pkg::POS_ANCNT) begin
          a_left = shift16;
          if (shift16 == '0)
            hdr_ok = 1'b0;
        end
        if (field_pos == dnsx_pkg::POS_HDEND) begin
          if (!hdr_ok)
            parse_phase = dnsx_pkg::PH_IGNORE;
          else if (q_left == '0)
            parse_phase = dnsx_pkg::PH_NAME_FIRST;
          else
            parse_phase = dnsx_pkg::PH_QNAME;
        end
        field_pos = field_pos + 16'd1;
      end
      dnsx_pkg::PH_QNAME: begin
        if (b == 8'd0) begin
          b_left      = dnsx_pkg::QTAIL_LEN;
          parse_phase = dnsx_pkg::PH_QTAIL;
        end
      end
      dnsx_pkg::PH_QTAIL: begin
        b_left = b_left - 16'd1;
        if (b_left == '0) begin
          q_left      = q_left - 16'd1;
          parse_phase = (q_left == '0) ? dnsx_pkg::PH_NAME_FIRST : dnsx_pkg::PH_QNAME;
        end
      end
      dnsx_pkg::PH_NAME_FIRST: begin
        field_pos = '0;
        if ((b & dnsx_pkg::PTR_MASK) == dnsx_pkg::PTR_MASK)
          parse_phase = dnsx_pkg::PH_NAME_PTR;
        else if (b == 8'd0)
          parse_phase = dnsx_pkg::PH_FIXED;
        else
          parse_phase = dnsx_pkg::PH_NAME_RUN;
      end
      dnsx_pkg::PH_NAME_PTR: parse_phase = dnsx_pkg::PH_FIXED;
      dnsx_pkg::PH_NAME_RUN: begin
        if (b == 8'd0)
          parse_phase = dnsx_pkg::PH_FIXED;
      end
      dnsx_pkg::PH_FIXED: begin
        shift16 = {shift16[7:0], b};
        if (field_pos == dnsx_pkg::POS_TYPE)
          rec_type = shift16;
        if (field_pos == dnsx_pkg::POS_RDLEN) begin
          rec_len = shift16;
          b_left  = shift16;
          if (shift16 == '0)
            close_record();
          else
            parse_phase = dnsx_pkg::PH_DATA;
        end
        field_pos = field_pos + 16'd1;
      end
      dnsx_pkg::PH_DATA: begin
        if (rec_type == dnsx_pkg::TYPE_A && rec_len == dnsx_pkg::SIZE_A)
          v4_addr = {v4_addr[23:0], b};
        if (rec_type == dnsx_pkg::TYPE_AAAA && rec_len == dnsx_pkg::SIZE_AAAA && !v6_seen)
          v6_addr = {v6_addr[119:0], b};
        b_left = b_left - 16'd1;
        if (b_left == '0)
          close_record();
      end
      default: ;
    endcase
  endfunction

  // address reported for the packet just ended
  function automatic dnsx_pkg::out_t close_packet();
    dnsx_pkg::out_t r;
    r = '0;
    if (v4_seen) begin
      r.result_kind = dnsx_pkg::KIND_A;
      r.address_low = {32'd0, v4_addr};
    end else if (v6_seen) begin
      r.result_kind  = dnsx_pkg::KIND_AAAA;
      r.address_high = v6_addr[127:64];
      r.address_low  = v6_addr[63:0];
    end else begin
      r.result_kind = dnsx_pkg::KIND_NONE;
    end
    clear_parse();
    return r;
  endfunction

  // ---------------------------------------------------------------- reply builders

  function automatic void put16(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endfunction

  function automatic void start_reply(input logic [15:0] id, input logic [15:0] flags,
                                      input logic [15:0] qd, input logic [15:0] an);
    pkt.delete();
    put16(id);
    put16(flags);
    put16(qd);
    put16(an);
    put16(16'($urandom));
    put16(16'($urandom));
  endfunction

  // one or two short labels closed by a zero byte
  function automatic void put_labels();
    int n;
    int len;
    int i;
    int j;
    n = $urandom_range(1, 2);
    for (i = 0; i < n; i++) begin
      len = $urandom_range(1, 4);
      pkt.push_back(8'(len));
      for (j = 0; j < len; j++)
        pkt.push_back(8'($urandom_range(1, 255)));
    end
    pkt.push_back(8'd0);
  endfunction

  function automatic void put_question();
    put_labels();
    repeat (4) pkt.push_back(8'($urandom));
  endfunction

  // compressed pointer, root name or label run
  function automatic void put_name();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      pkt.push_back(dnsx_pkg::PTR_MASK | 8'($urandom_range(63)));
      pkt.push_back(8'($urandom));
    end else if (r < 75) begin
      pkt.push_back(8'd0);
    end else begin
      put_labels();
    end
  endfunction

  // fill below zero means random data bytes
  function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rlen,
                                     input int fill);
    int k;
    put_name();
    put16(rtype);
    put16(CLASS_IN);
    put16(16'($urandom));
    put16(16'($urandom));
    put16(rlen);
    for (k = 0; k < rlen; k++)
      pkt.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
  endfunction

  function automatic void put_random_record();
    int r;
    r = $urandom_range(99);
    if (r < 30)
      put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, -1);
    else if (r < 60)
      put_record(dnsx_pkg::TYPE_AAAA, dnsx_pkg::SIZE_AAAA, -1);
    else if (r < 72)
      put_record(TYPE_CNAME, 16'($urandom_range(0, 6)), -1);
    else if (r < 78)
      put_record(dnsx_pkg::TYPE_A, 16'($urandom_range(0, 6)), -1);
    else if (r < 84)
      put_record(dnsx_pkg::TYPE_AAAA, 16'($urandom_range(0, 20)), -1);
    else
      put_record(16'($urandom), 16'($urandom_range(0, 8)), -1);
  endfunction

  // mostly well-formed replies with random content, some noise and broken ones
  function automatic void build_random_reply();
    int          r;
    int          n;
    int          k;
    logic [15:0] id;
    logic [15:0] flags;
    logic [15:0] qd;
    logic [15:0] an;
    r = $urandom_range(99);
    if (r < 8) begin
      pkt.delete();
      n = $urandom_range(1, 30);
      for (k = 0; k < n; k++)
        pkt.push_back(8'($urandom));
      return;
    end
    id = ($urandom_range(9) == 0) ? 16'($urandom) : model_id;
    if ($urandom_range(9) == 0)
      flags = 16'($urandom);
    else
      flags = dnsx_pkg::FLAG_RESPONSE |
              (16'($urandom) & ~(dnsx_pkg::FLAG_RESPONSE | dnsx_pkg::RCODE_MASK));
    qd = 16'($urandom_range(0, 2));
    if ($urandom_range(29) == 0)
      qd = 16'($urandom);
    n  = $urandom_range(1, 4);
    an = 16'(n);
    k  = $urandom_range(19);
    if (k == 0)
      an = '0;
    else if (k == 1)
      an = 16'($urandom);
    else if (k == 2)
      an = 16'(n - 1);
    start_reply(id, flags, qd, an);
    for (k = 0; k < qd && k < 3; k++)
      put_question();
    for (k = 0; k < n; k++)
      put_random_record();
    // trailing junk after the records
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
    // cut the packet short
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(1, pkt.size());
      while (pkt.size() > n)
        void'(pkt.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // one byte item; the model takes it on acceptance
  task automatic send_item(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= dnsx_pkg::in_t'({b, last});
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    items_sent++;
    parse_reply_byte(b);
    if (last)
      address_q.push_back(close_packet());
  endtask

  task automatic send_reply();
    int k;
    for (k = 0; k < pkt.size(); k++)
      send_item(pkt[k], k == pkt.size() - 1);
  endtask

  // stop offering and wait for every outstanding address
  task automatic pause_sender();
    @(negedge clk);
    in_valid <= 1'b0;
    while (address_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic set_expected_id(input logic [15:0] v);
    pause_sender();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_id  = v;
  endtask

  // result side: random stalls plus long hold-offs on request
  initial begin : result_sink
    int hold_left;
    out_ready = 1'b0;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request > 0) begin
        hold_left    = hold_request - 1;
        hold_request = 0;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare each address item with the oldest expectation
  always @(posedge clk) begin : address_check
    dnsx_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (address_q.size() == 0) begin
        $error("unexpected result item: result_kind %0d", out_data.result_kind);
        mismatches++;
      end else begin
        want = address_q.pop_front();
        if (out_data.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind,
                 out_data.result_kind);
          mismatches++;
        end
        if (out_data.address_high !== want.address_high) begin
          $error("address_high: expected %h, got %h", want.address_high,
                 out_data.address_high);
          mismatches++;
        end
        if (out_data.address_low !== want.address_low) begin
          $error("address_low: expected %h, got %h", want.address_low,
                 out_data.address_low);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // packets too short for a header, and a header with no record
  task automatic test_short_packets();
    pkt.delete();
    pkt.push_back(8'hFF);
    send_reply();
    start_reply(16'h0000, FLAGS_OK, 16'd0, 16'd1);
    void'(pkt.pop_back());
    send_reply();
    // header alone, no record behind it
    start_reply(16'h0000, FLAGS_OK, 16'd0, 16'd1);
    send_reply();
  endtask

  // id, response bit, rcode and answer count
  task automatic test_header_checks();
    start_reply(16'h0000, FLAGS_OK, 16'd0, 16'd1);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, 'h00);
    send_reply();
    set_expected_id(16'hFFFF);
    start_reply(16'hFFFE, FLAGS_OK, 16'd0, 16'd1);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, -1);
    send_reply();
    start_reply(16'hFFFF, FLAGS_OK & ~dnsx_pkg::FLAG_RESPONSE, 16'd0, 16'd1);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, -1);
    send_reply();
    start_reply(16'hFFFF, FLAGS_OK | 16'h0003, 16'd0, 16'd1);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, -1);
    send_reply();
    start_reply(16'hFFFF, FLAGS_OK, 16'd0, 16'd0);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, -1);
    send_reply();
    // all flag bits but rcode set, largest answer count
    start_reply(16'hFFFF, 16'hFFF0, 16'd0, 16'hFFFF);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, 'hFF);
    send_reply();
  endtask

  // record walk and precedence between a and aaaa
  task automatic test_address_records();
    set_expected_id(16'h5A3C);
    // aaaa first, a later still wins
    start_reply(16'h5A3C, FLAGS_OK, 16'd1, 16'd2);
    put_question();
    put_record(dnsx_pkg::TYPE_AAAA, dnsx_pkg::SIZE_AAAA, 'hFF);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, -1);
    send_reply();
    start_reply(16'h5A3C, FLAGS_OK, 16'd0, 16'd1);
    put_record(dnsx_pkg::TYPE_AAAA, dnsx_pkg::SIZE_AAAA, 'hFF);
    send_reply();
    // a first, everything after ignored
    start_reply(16'h5A3C, FLAGS_OK, 16'd0, 16'd3);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, -1);
    put_record(dnsx_pkg::TYPE_AAAA, dnsx_pkg::SIZE_AAAA, -1);
    repeat (5) pkt.push_back(8'($urandom));
    send_reply();
    // first of two aaaa records kept
    start_reply(16'h5A3C, FLAGS_OK, 16'd0, 16'd2);
    put_record(dnsx_pkg::TYPE_AAAA, dnsx_pkg::SIZE_AAAA, 'h00);
    put_record(dnsx_pkg::TYPE_AAAA, dnsx_pkg::SIZE_AAAA, -1);
    send_reply();
    // a record cut off by the end of the packet
    start_reply(16'h5A3C, FLAGS_OK, 16'd0, 16'd1);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, -1);
    void'(pkt.pop_back());
    void'(pkt.pop_back());
    send_reply();
    // answers used up before the a record
    start_reply(16'h5A3C, FLAGS_OK, 16'd0, 16'd1);
    put_record(TYPE_CNAME, 16'd3, -1);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, -1);
    send_reply();
    start_reply(16'h5A3C, FLAGS_OK, 16'd0, 16'd1);
    put_record(dnsx_pkg::TYPE_AAAA, dnsx_pkg::SIZE_AAAA, -1);
    put_record(dnsx_pkg::TYPE_A, dnsx_pkg::SIZE_A, -1);
    send_reply();
    // a type with the wrong size, then an empty record
    start_reply(16'h5A3C, FLAGS_OK, 16'd0, 16'd2);
    put_record(dnsx_pkg::TYPE_A, 16'd5, -1);
    put_record(TYPE_CNAME, 16'd0, -1);
    send_reply();
  endtask

  // random replies in phases, each phase with its own id
  task automatic test_random_traffic();
    int          phase_no;
    int          k;
    logic [15:0] id;
    phase_no = 0;
    while (items_sent < RANDOM_STOP) begin
      case (phase_no)
        0:       id = 16'h0000;
        1:       id = 16'hFFFF;
        default: id = 16'($urandom);
      endcase
      set_expected_id(id);
      for (k = 0; k < REPLIES_PER_ID && items_sent < RANDOM_STOP; k++) begin
        build_random_reply();
        send_reply();
      end
      phase_no++;
    end
  endtask

  // long stretch with no idling on either side
  task automatic test_back_to_back();
    int k;
    set_expected_id(16'($urandom));
    calm = 1'b1;
    for (k = 0; k < B2B_REPLIES; k++) begin
      build_random_reply();
      send_reply();
    end
    calm = 1'b0;
  endtask

  // result side held off while replies keep coming
  task automatic test_output_backpressure();
    int k;
    set_expected_id(16'($urandom));
    hold_request = 300;
    for (k = 0; k < HOLD_REPLIES; k++) begin
      build_random_reply();
      send_reply();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    calm         = 1'b0;
    hold_request = 0;
    mismatches   = 0;
    items_sent   = 0;
    model_id     = '0;
    clear_parse();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_packets();
    test_header_checks();
    test_address_records();
    test_random_traffic();
    test_back_to_back();
    test_output_backpressure();

    pause_sender();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ dns_response_address_extractor.f @@
hw/rtl/dnsx_pkg.sv
hw/rtl/dnsx_parser.sv
hw/rtl/dns_response_address_extractor.sv
test/dns_response_address_extractor_tb.sv
